// ===== rtl/miller_rabin_witness_test_unit_defines.svh =====
// Assertion macros used by the port-level checker.
`ifndef MILLER_RABIN_WITNESS_TEST_UNIT_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define MRW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define MRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/mrw_pkg.sv =====
// Shared types, constants and functions for the Miller-Rabin witness test unit.
package mrw_pkg;
  localparam int unsigned ModBits   = 16;
  localparam int unsigned CntBits   = $clog2(ModBits + 1);
  localparam int unsigned PrimeCnt  = 24;
  localparam int unsigned PrimeIdxW = $clog2(PrimeCnt);

  typedef logic [ModBits-1:0]   mod_t;
  typedef logic [2*ModBits-1:0] prod_t;
  typedef logic [1:0]           verdict_t;

  localparam verdict_t VerdictPrime   = 2'd0;
  localparam verdict_t VerdictDivides = 2'd1;
  localparam verdict_t VerdictWitness = 2'd2;
  localparam verdict_t VerdictInvalid = 2'd3;

  typedef enum logic [3:0] {
    StIdle, StCheck, StTrialStart, StTrialWait, StPowSetup, StMulStart,
    StMulWait, StSqStart, StSqWait, StEval, StLoopStart, StLoopWait, StDone
  } state_e;

  typedef enum logic [1:0] {
    MulAccSq, MulSqSq, MulVV, MulTrial
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     setup;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     trial_next;
    logic     mul_to_acc;
    logic     mul_to_sq;
    logic     expo_shift;
    logic     iter_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic invalid;
    logic mul_done;
    logic rem_zero;
    logic trial_last;
    logic expo_zero;
    logic expo_lsb;
    logic v_one;
    logic v_nm1;
    logic iter_end;
  } dp_sts_t;

  function automatic logic [6:0] small_prime(input logic [PrimeIdxW-1:0] idx);
    logic [6:0] p;
    unique case (idx)
      5'd0: p = 7'd3;    5'd1: p = 7'd5;    5'd2: p = 7'd7;    5'd3: p = 7'd11;
      5'd4: p = 7'd13;   5'd5: p = 7'd17;   5'd6: p = 7'd19;   5'd7: p = 7'd23;
      5'd8: p = 7'd29;   5'd9: p = 7'd31;   5'd10: p = 7'd37;  5'd11: p = 7'd41;
      5'd12: p = 7'd43;  5'd13: p = 7'd47;  5'd14: p = 7'd53;  5'd15: p = 7'd59;
      5'd16: p = 7'd61;  5'd17: p = 7'd67;  5'd18: p = 7'd71;  5'd19: p = 7'd73;
      5'd20: p = 7'd79;  5'd21: p = 7'd83;  5'd22: p = 7'd89;  5'd23: p = 7'd97;
      default: p = 7'd97;
    endcase
    return p;
  endfunction
endpackage

// ===== rtl/mrw_if.sv =====
// Valid/ready channel interfaces for candidate items and verdict items.
interface mrw_in_if;
  logic               valid;
  logic               ready;
  mrw_pkg::mod_t      candidate;
  mrw_pkg::mod_t      witness;
  modport source (output valid, candidate, witness, input ready);
  modport sink (input valid, candidate, witness, output ready);
endinterface

interface mrw_out_if;
  logic              valid;
  logic              ready;
  mrw_pkg::verdict_t verdict;
  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

// ===== rtl/mrw_modmul.sv =====
// Multi-cycle modular multiplier: a registered full product, then a restoring remainder.
module mrw_modmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mrw_pkg::mod_t a_i,
  input  mrw_pkg::mod_t b_i,
  input  mrw_pkg::mod_t m_i,
  output logic          done_o,
  output mrw_pkg::mod_t rem_o
);
  import mrw_pkg::*;

  localparam int unsigned StepW = $clog2(2 * ModBits + 1);

  prod_t                 prod_q, prod_d;
  logic [ModBits:0]      rem_q, rem_d;
  mod_t                  m_q, m_d;
  logic [StepW-1:0]      step_q, step_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [ModBits:0]      shifted;

  assign shifted = {rem_q[ModBits-1:0], prod_q[2*ModBits-1]};

  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    m_d    = m_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      prod_d = prod_t'(a_i) * prod_t'(b_i);
      rem_d  = '0;
      m_d    = m_i;
      step_d = StepW'(2 * ModBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift in one product bit, subtract the modulus when it fits.
      prod_d = {prod_q[2*ModBits-2:0], 1'b0};
      if (shifted >= {1'b0, m_q}) rem_d = shifted - {1'b0, m_q};
      else rem_d = shifted;
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    m_q    <= m_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[ModBits-1:0];
endmodule

// ===== rtl/mrw_datapath.sv =====
// Datapath: operand registers, exponent, trial index and the shared multiplier.
module mrw_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrw_pkg::mod_t    candidate_i,
  input  mrw_pkg::mod_t    witness_i,
  input  mrw_pkg::dp_cmd_t cmd_i,
  output mrw_pkg::dp_sts_t sts_o
);
  import mrw_pkg::*;

  mod_t                 n_q, b_q, acc_q, sq_q, expo_q;
  logic [CntBits-1:0]   j_q, i_q;
  logic [PrimeIdxW-1:0] tidx_q;
  mod_t                 nm1, mul_a, mul_b, mul_m, rem;
  logic                 mul_done;
  logic [CntBits-1:0]   tz;

  assign nm1 = n_q - 1'b1;

  // Count trailing zeros of n-1.
  always_comb begin
    logic found;
    tz    = '0;
    found = 1'b0;
    for (int k = 0; k < ModBits; k++) begin
      if (!found) begin
        if (nm1[k]) found = 1'b1;
        else tz = tz + 1'b1;
      end
    end
  end

  always_comb begin
    mul_a = acc_q;
    mul_b = sq_q;
    mul_m = n_q;
    case (cmd_i.mul_sel)
      MulAccSq: begin mul_a = acc_q; mul_b = sq_q; end
      MulSqSq:  begin mul_a = sq_q;  mul_b = sq_q; end
      MulVV:    begin mul_a = acc_q; mul_b = acc_q; end
      MulTrial: begin
        mul_a = n_q;
        mul_b = mod_t'(1);
        mul_m = mod_t'(small_prime(tidx_q));
      end
      default: ;
    endcase
  end

  mrw_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mul_m),
    .done_o  (mul_done),
    .rem_o   (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= candidate_i;
      b_q <= witness_i;
    end
    if (cmd_i.setup) begin
      acc_q  <= mod_t'(1);
      sq_q   <= b_q;
      expo_q <= nm1 >> tz;
      j_q    <= tz;
      i_q    <= CntBits'(1);
    end
    if (cmd_i.mul_to_acc) acc_q <= rem;
    if (cmd_i.mul_to_sq) sq_q <= rem;
    if (cmd_i.expo_shift) expo_q <= expo_q >> 1;
    if (cmd_i.iter_inc) i_q <= i_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tidx_q <= '0;
    else if (cmd_i.load) tidx_q <= '0;
    else if (cmd_i.trial_next) tidx_q <= tidx_q + 1'b1;
  end

  assign sts_o.invalid    = (n_q < mod_t'(5)) || !n_q[0] || (b_q < mod_t'(2)) ||
                            (b_q > n_q - mod_t'(2));
  assign sts_o.mul_done   = mul_done;
  assign sts_o.rem_zero   = (rem == '0);
  assign sts_o.trial_last = (tidx_q == PrimeIdxW'(PrimeCnt - 1));
  assign sts_o.expo_zero  = (expo_q == '0);
  assign sts_o.expo_lsb   = expo_q[0];
  // A value of one counts only straight after the exponentiation, not after a squaring.
  assign sts_o.v_one      = (acc_q == mod_t'(1)) && (i_q == CntBits'(1));
  assign sts_o.v_nm1      = (acc_q == nm1);
  assign sts_o.iter_end   = (i_q >= j_q);
endmodule

// ===== rtl/mrw_ctrl.sv =====
// Controller state machine sequencing trial division and the witness round.
module mrw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrw_pkg::verdict_t  verdict_o,
  output mrw_pkg::dp_cmd_t   cmd_o,
  input  mrw_pkg::dp_sts_t   sts_i
);
  import mrw_pkg::*;

  state_e   state_q, state_d;
  verdict_t verdict_q, verdict_d;

  always_comb begin
    state_d   = state_q;
    verdict_d = verdict_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StCheck;
      StCheck: begin
        if (sts_i.invalid) begin
          verdict_d = VerdictInvalid;
          state_d   = StDone;
        end else state_d = StTrialStart;
      end
      StTrialStart: state_d = StTrialWait;
      StTrialWait: if (sts_i.mul_done) begin
        if (sts_i.rem_zero) begin
          verdict_d = VerdictDivides;
          state_d   = StDone;
        end else if (sts_i.trial_last) state_d = StPowSetup;
        else state_d = StTrialStart;
      end
      StPowSetup: state_d = StMulStart;
      StMulStart: begin
        if (sts_i.expo_zero) state_d = StEval;
        else if (sts_i.expo_lsb) state_d = StMulWait;
        else state_d = StSqStart;
      end
      StMulWait: if (sts_i.mul_done) state_d = StSqStart;
      StSqStart: state_d = StSqWait;
      StSqWait: if (sts_i.mul_done) state_d = StMulStart;
      StEval: begin
        if (sts_i.v_one || sts_i.v_nm1) begin
          verdict_d = VerdictPrime;
          state_d   = StDone;
        end else if (sts_i.iter_end) begin
          verdict_d = VerdictWitness;
          state_d   = StDone;
        end else state_d = StLoopStart;
      end
      StLoopStart: state_d = StLoopWait;
      StLoopWait: if (sts_i.mul_done) state_d = StEval;
      StDone: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_sel = MulAccSq;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StTrialStart: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MulTrial;
      end
      StTrialWait: begin
        cmd_o.mul_sel    = MulTrial;
        cmd_o.trial_next = sts_i.mul_done;
      end
      StPowSetup: cmd_o.setup = 1'b1;
      StMulStart: begin
        cmd_o.mul_start = !sts_i.expo_zero && sts_i.expo_lsb;
        cmd_o.mul_sel   = MulAccSq;
      end
      StMulWait: cmd_o.mul_to_acc = sts_i.mul_done;
      StSqStart: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MulSqSq;
      end
      StSqWait: begin
        cmd_o.mul_to_sq  = sts_i.mul_done;
        cmd_o.expo_shift = sts_i.mul_done;
      end
      StLoopStart: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MulVV;
      end
      StLoopWait: begin
        cmd_o.mul_to_acc = sts_i.mul_done;
        cmd_o.iter_inc   = sts_i.mul_done;
      end
      StDone: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      verdict_q <= VerdictInvalid;
    end else begin
      state_q   <= state_d;
      verdict_q <= verdict_d;
    end
  end

  assign verdict_o = verdict_q;
endmodule

// ===== rtl/miller_rabin_witness_test_unit.sv =====
// One shared modular multiplier serves every multiply. Trial division divides the
// candidate by each small prime in turn, all 24 when none divides it; the round then
// does at most a multiply and a squaring per exponent bit, plus one squaring per
// extra loop step. Invalid inputs get their verdict from the check state, with no multiply.
// One item is in work at a time; the next is taken the cycle after the verdict leaves.
// Reset is asynchronous, active low, and returns the controller to idle.
module miller_rabin_witness_test_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  mrw_in_if.sink   in_i,
  mrw_out_if.source out_o
);
  import mrw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mrw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .verdict_o   (out_o.verdict),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mrw_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .candidate_i (in_i.candidate),
    .witness_i   (in_i.witness),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );
endmodule

// ===== rtl/mrw_checker.sv =====
// Port-level checker for the Miller-Rabin witness test unit, with its bind.
`include "miller_rabin_witness_test_unit_defines.svh"
module mrw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mrw_pkg::verdict_t verdict
);
  `MRW_ASSERT_IMPL(a_no_accept_while_out, clk_i, rst_ni, out_valid, !in_ready)
  `MRW_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(verdict))
  `MRW_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready && !out_valid)
  `MRW_ASSERT_NEXT(a_idle_after_out, clk_i, rst_ni, out_valid && out_ready, in_ready && !out_valid)
endmodule

bind miller_rabin_witness_test_unit mrw_checker u_mrw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .verdict   (out_o.verdict)
);
